FILE: rtl/core/utf8_char_decoder_top_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_CHAR_DECODER_TOP_ASSERT_SVH
`define UTF8_CHAR_DECODER_TOP_ASSERT_SVH

// a true at an edge requires c true at the same edge
`define UTF8D_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("utf8 decoder assertion failed");

// a true at an edge requires c true at the next edge
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("utf8 decoder assertion failed");

`endif

FILE: rtl/core/utf8d_pkg.sv
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 31;
	localparam int CNT_W  = 3;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EOI      = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_LEAD = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_CONT = 2'd3;

	// one input word
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_input;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic [CP_W-1:0]   code_point;
		logic [CNT_W-1:0]  byte_count;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

FILE: rtl/core/utf8d_in_reg.sv
module utf8d_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  utf8d_pkg::in_word_t word_in,
	input  logic               fire,
	output logic               valid_s1,
	output utf8d_pkg::in_word_t word_s1
);
	import utf8d_pkg::*;

	logic valid_q;

	// hold only while the staged word cannot retire
	assign byte_stall = valid_q && !fire;
	assign valid_s1   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!byte_stall) begin
			valid_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			word_s1 <= word_in;
		end
	end

endmodule

FILE: rtl/core/utf8d_decode.sv
module utf8d_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8d_pkg::in_word_t word_s1,
	input  logic                fire,
	output logic                has_result,
	output utf8d_pkg::result_t  result
);
	import utf8d_pkg::*;

	`include "utf8_char_decoder_top_assert.svh"

	logic [CNT_W-1:0] remaining_q, remaining_d;
	logic [CP_W-1:0]  partial_q, partial_d;
	logic [CNT_W-1:0] length_q, length_d;
	logic [CP_W-1:0]  shifted;
	logic [BYTE_W-1:0] b;
	logic             eoi;

	assign b       = word_s1.in_byte;
	assign eoi     = word_s1.end_of_input;
	assign shifted = {partial_q[CP_W-7:0], b[5:0]};

	always_comb begin
		remaining_d = remaining_q;
		partial_d   = partial_q;
		length_d    = length_q;
		has_result  = 1'b0;
		result      = '0;
		if (remaining_q != '0) begin
			if (eoi || b[7:6] != 2'b10) begin
				// bad or missing continuation: drop the partial character
				has_result    = 1'b1;
				result.status = ST_BAD_CONT;
				remaining_d   = '0;
				partial_d     = '0;
				length_d      = '0;
			end else if (remaining_q == CNT_W'(1)) begin
				has_result        = 1'b1;
				result.code_point = shifted;
				result.byte_count = length_q;
				result.status     = ST_OK;
				remaining_d       = '0;
				partial_d         = '0;
				length_d          = '0;
			end else begin
				partial_d   = shifted;
				remaining_d = remaining_q - CNT_W'(1);
			end
		end else if (eoi) begin
			has_result    = 1'b1;
			result.status = ST_EOI;
		end else if (!b[7]) begin
			has_result        = 1'b1;
			result.code_point = CP_W'(b);
			result.byte_count = CNT_W'(1);
			result.status     = ST_OK;
		end else if (b[7:5] == 3'b110) begin
			partial_d   = CP_W'(b[4:0]);
			length_d    = CNT_W'(2);
			remaining_d = CNT_W'(1);
		end else if (b[7:4] == 4'b1110) begin
			partial_d   = CP_W'(b[3:0]);
			length_d    = CNT_W'(3);
			remaining_d = CNT_W'(2);
		end else if (b[7:3] == 5'b11110) begin
			partial_d   = CP_W'(b[2:0]);
			length_d    = CNT_W'(4);
			remaining_d = CNT_W'(3);
		end else if (b[7:2] == 6'b111110) begin
			partial_d   = CP_W'(b[1:0]);
			length_d    = CNT_W'(5);
			remaining_d = CNT_W'(4);
		end else if (b[7:1] == 7'b1111110) begin
			partial_d   = CP_W'(b[0]);
			length_d    = CNT_W'(6);
			remaining_d = CNT_W'(5);
		end else begin
			// stray continuation byte, 0xFE or 0xFF
			has_result    = 1'b1;
			result.status = ST_BAD_LEAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			partial_q   <= '0;
			length_q    <= '0;
		end else if (fire) begin
			remaining_q <= remaining_d;
			partial_q   <= partial_d;
			length_q    <= length_d;
		end
	end

	`UTF8D_ASSERT_IMPL(a_rem_below_len, clk, arst_n, remaining_q != '0,
		remaining_q < length_q && length_q >= CNT_W'(2))
	`UTF8D_ASSERT_IMPL(a_idle_clear, clk, arst_n, remaining_q == '0,
		partial_q == '0 && length_q == '0)

endmodule

FILE: rtl/core/utf8d_out_reg.sv
module utf8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utf8d_pkg::result_t result,
	output logic               out_free,
	output logic               char_valid,
	input  logic               char_stall,
	output utf8d_pkg::result_t result_q
);
	import utf8d_pkg::*;

	logic valid_q;

	assign out_free   = !valid_q || !char_stall;
	assign char_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			result_q <= result;
		end
	end

endmodule

FILE: rtl/core/utf8_char_decoder_top.sv
// UTF-8 decoder for the original scheme: sequences of one to six bytes and
// code points of up to 31 bits, with no overlong or surrogate check. One
// byte word (or an end-of-input mark) is taken per clock, back to back, while
// byte_stall is low; a result word passes through the input register and then
// the result register. Lead and middle continuation bytes give no result.
// Results: status 0 with the code point and its byte count, 1 for end of
// input between characters, 2 for a bad lead byte (dropped), 3 for a bad or
// missing continuation byte (consumed, partial char dropped). Throughput is
// one word per cycle while byte_stall is low; a stalled result holds back
// only words that would produce another result, while one further byte can
// wait in the input register.
module utf8_char_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [30:0] code_point,
	output logic [2:0]  byte_count,
	output logic [1:0]  status
);
	import utf8d_pkg::*;

	`include "utf8_char_decoder_top_assert.svh"

	in_word_t word_in, word_s1;
	result_t  result, result_q;
	logic     valid_s1, fire, has_result, out_free;

	assign word_in.in_byte      = in_byte;
	assign word_in.end_of_input = end_of_input;

	// staged word retires unless it has a result and the output is full
	assign fire = valid_s1 && (!has_result || out_free);

	utf8d_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.word_in    (word_in),
		.fire       (fire),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	utf8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_s1    (word_s1),
		.fire       (fire),
		.has_result (has_result),
		.result     (result)
	);

	utf8d_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && has_result),
		.result     (result),
		.out_free   (out_free),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.result_q   (result_q)
	);

	assign code_point = result_q.code_point;
	assign byte_count = result_q.byte_count;
	assign status     = result_q.status;

	`UTF8D_ASSERT_IMPL(a_ok_has_count, clk, arst_n, char_valid && status == ST_OK,
		byte_count != '0 && byte_count <= CNT_W'(6))
	`UTF8D_ASSERT_IMPL(a_err_zero, clk, arst_n, char_valid && status != ST_OK,
		code_point == '0 && byte_count == '0)
	`UTF8D_ASSERT_IMPL(a_ascii_range, clk, arst_n,
		char_valid && status == ST_OK && byte_count == CNT_W'(1), code_point[30:7] == '0)
	`UTF8D_ASSERT_NEXT(a_result_lands, clk, arst_n, fire && has_result, char_valid)

endmodule

FILE: tb/tb_utf8_char_decoder_top.sv
`timescale 1ns / 1ps

// Testbench for utf8_char_decoder_top.
// Byte words go in through a valid/stall handshake, decoded char words come
// out through another. A local decoder model runs on every accepted byte word
// and queues the char word it should produce; the checker pops that queue on
// every accepted char word and compares all three fields.
// Test sequence: directed edge cases, random streams with idling on both
// sides, a back-to-back stretch with no idling, and a long receiver hold-off
// that backs the decoder up into its input, then more random streams.
module tb_utf8_char_decoder_top;
	import utf8d_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  in_byte;
	logic        end_of_input;
	logic        char_valid;
	logic        char_stall;
	logic [30:0] code_point;
	logic [2:0]  byte_count;
	logic [1:0]  status;

	// model state: continuation bytes still due, payload so far, sequence length
	logic [2:0]  cont_left = '0;
	logic [30:0] cp_acc    = '0;
	logic [2:0]  seq_len   = '0;

	result_t     pending_chars[$];
	result_t     want_char;
	result_t     got_char;
	int          errors     = 0;
	int          words_sent = 0;
	bit          idle_on    = 1'b1;
	bit          hold_req   = 1'b0;
	int          hold_left  = 0;

	utf8_char_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.code_point   (code_point),
		.byte_count   (byte_count),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the handshakes lock up.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Queue one expected char word.
	task automatic push_char(input logic [30:0] cp, input logic [2:0] cnt,
			input logic [1:0] st);
		result_t r;
		r.code_point = cp;
		r.byte_count = cnt;
		r.status     = st;
		pending_chars.push_back(r);
	endtask

	task automatic drop_partial();
		cont_left = '0;
		cp_acc    = '0;
		seq_len   = '0;
	endtask

	// Decoder model: one accepted byte word in, zero or one char word queued.
	task automatic decode_step(input logic [7:0] b, input logic eoi);
		if (cont_left != 3'd0) begin
			// inside a sequence: anything but 10xxxxxx (or end mark) kills it,
			// and the offending byte is consumed
			if (eoi || b[7:6] != 2'b10) begin
				drop_partial();
				push_char('0, '0, ST_BAD_CONT);
			end else begin
				cp_acc    = {cp_acc[24:0], b[5:0]};
				cont_left = cont_left - 3'd1;
				if (cont_left == 3'd0) begin
					push_char(cp_acc, seq_len, ST_OK);
					drop_partial();
				end
			end
		end else if (eoi) begin
			push_char('0, '0, ST_EOI);
		end else if (b[7] == 1'b0) begin
			push_char({23'd0, b}, 3'd1, ST_OK);
		end else begin
			// lead byte: prefix picks length, remaining bits seed the payload
			if (b[7:5] == 3'b110) begin
				cp_acc  = {26'd0, b[4:0]};
				seq_len = 3'd2;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc  = {27'd0, b[3:0]};
				seq_len = 3'd3;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc  = {28'd0, b[2:0]};
				seq_len = 3'd4;
			end else if (b[7:2] == 6'b111110) begin
				cp_acc  = {29'd0, b[1:0]};
				seq_len = 3'd5;
			end else if (b[7:1] == 7'b1111110) begin
				cp_acc  = {30'd0, b[0]};
				seq_len = 3'd6;
			end
			if (seq_len == 3'd0) begin
				// 10xxxxxx, 0xFE, 0xFF: dropped, stay idle
				push_char('0, '0, ST_BAD_LEAD);
			end else begin
				cont_left = seq_len - 3'd1;
			end
		end
	endtask

	// Checker and model share the rising edge. The char word is checked
	// first; a byte accepted at this edge cannot produce a word at the same
	// edge, so the order only keeps the queue tidy.
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				got_char.code_point = code_point;
				got_char.byte_count = byte_count;
				got_char.status     = status;
				if (pending_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected char word: expected none, got cp=%h cnt=%0d st=%0d",
						$time, code_point, byte_count, status);
				end else begin
					want_char = pending_chars.pop_front();
					if (got_char !== want_char) begin
						errors++;
						$display("%0t: char mismatch: expected cp=%h cnt=%0d st=%0d, got cp=%h cnt=%0d st=%0d",
							$time, want_char.code_point, want_char.byte_count,
							want_char.status, code_point, byte_count, status);
					end
				end
			end
			if (byte_valid && !byte_stall)
				decode_step(in_byte, end_of_input);
		end
	end

	// Receiver side: random stall, or a counted hold-off when one is asked.
	initial begin
		char_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				char_stall = 1'b1;
				hold_left--;
			end else begin
				char_stall = idle_on && ($urandom_range(0, 99) < 22);
			end
		end
	end

	// Offer one byte word and hold it until the decoder takes it.
	task automatic send_word(input logic [7:0] b, input logic eoi);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 22) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid   = 1'b1;
		in_byte      = b;
		end_of_input = eoi;
		do @(posedge clk); while (byte_stall);
		words_sent++;
	endtask

	// Mostly well-formed characters with random payload; some noise bytes,
	// end marks, and sequences cut short by a bad byte or an end mark.
	task automatic send_random_char();
		int          kind;
		int          len;
		int          cut;
		logic [31:0] r;
		logic [7:0]  bad;
		kind = $urandom_range(0, 99);
		r    = $urandom;
		len  = $urandom_range(1, 6);
		if (kind < 8) begin
			send_word(r[7:0], 1'b0);
		end else if (kind < 11) begin
			send_word(r[7:0], 1'b1);
		end else begin
			case (len)
				1: send_word({1'b0, r[6:0]}, 1'b0);
				2: send_word({3'b110, r[4:0]}, 1'b0);
				3: send_word({4'b1110, r[3:0]}, 1'b0);
				4: send_word({5'b11110, r[2:0]}, 1'b0);
				5: send_word({6'b111110, r[1:0]}, 1'b0);
				default: send_word({7'b1111110, r[0]}, 1'b0);
			endcase
			// broken sequence: stop early and inject something that is not
			// a continuation byte
			cut = (kind < 22 && len > 1) ? $urandom_range(1, len - 1) : len;
			for (int i = 1; i < cut; i++)
				send_word({2'b10, 6'($urandom)}, 1'b0);
			if (cut < len) begin
				bad = 8'($urandom);
				if (bad[7:6] == 2'b10)
					bad[6] = 1'b1;
				send_word(bad, $urandom_range(0, 99) < 30);
			end
		end
	endtask

	// Smallest and largest ASCII values, the smallest 2-byte value, and the largest 3-byte and 6-byte values.
	task automatic test_value_extremes();
		send_word(8'h00, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'hC0, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hEF, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hBF, 1'b0);
		// 6-byte form with all payload bits set: 0x7FFFFFFF
		send_word(8'hFD, 1'b0);
		repeat (5) send_word(8'hBF, 1'b0);
	endtask

	// Bad lead bytes, end marks, bad and missing continuation bytes.
	task automatic test_error_cases();
		send_word(8'h80, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'hFE, 1'b0);
		send_word(8'hFF, 1'b0);
		// end mark while idle, twice; the byte lane is ignored
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b1);
		// ASCII byte where a continuation was due: consumed as error
		send_word(8'hF0, 1'b0);
		send_word(8'h90, 1'b0);
		send_word(8'h41, 1'b0);
		// input ends inside a sequence
		send_word(8'hE2, 1'b0);
		send_word(8'h82, 1'b1);
	endtask

	task automatic test_random_streams(input int target);
		idle_on = 1'b1;
		while (words_sent < target)
			send_random_char();
	endtask

	task automatic test_back_to_back(input int target);
		idle_on = 1'b0;
		while (words_sent < target)
			send_random_char();
		idle_on = 1'b1;
	endtask

	// Receiver holds off while the sender keeps pushing, so the decoder
	// backs up and stalls its byte input.
	task automatic test_fill_and_stall(input int target);
		idle_on  = 1'b0;
		hold_req = 1'b1;
		while (words_sent < target)
			send_random_char();
		idle_on = 1'b1;
	endtask

	initial begin
		int drain_cnt;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		in_byte      = '0;
		end_of_input = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_value_extremes();
		test_error_cases();
		test_random_streams(600);
		test_back_to_back(950);
		test_fill_and_stall(1050);
		test_random_streams(1350);

		@(negedge clk);
		byte_valid = 1'b0;

		drain_cnt = 0;
		while (pending_chars.size() != 0 && drain_cnt < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cnt++;
		end
		// wait on past the last expected word
		repeat (10) @(posedge clk);
		if (pending_chars.size() != 0)
			$display("%0t: %0d expected char words never arrived", $time,
				pending_chars.size());

		if (errors == 0 && pending_chars.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
